@@ rtl/core/btbt_pkg.sv @@
// Package: constants, opcodes and types for the batch token budget tracker.
package btbt_pkg;

  localparam int unsigned IdTableDepth = 64;
  localparam int unsigned IdWidth      = 32;
  localparam int unsigned IdxW         = $clog2(IdTableDepth);
  localparam int unsigned CntW         = $clog2(IdTableDepth + 1);

  localparam int unsigned OpW   = 3;
  localparam int unsigned TagW  = 32;
  localparam int unsigned TokW  = 24;
  localparam int unsigned SeqW  = 12;
  localparam int unsigned Cnt32W = 32;
  localparam int unsigned Cnt16W = 16;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [OpW-1:0] OpChargeTok  = 3'd0;
  localparam logic [OpW-1:0] OpChargeSeq  = 3'd1;
  localparam logic [OpW-1:0] OpReleaseTok = 3'd2;
  localparam logic [OpW-1:0] OpReleaseSeq = 3'd3;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatIgnore = 2'd1;
  localparam logic [StatW-1:0] StatFull   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegTokenLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeqLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChunkedEn  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegChunkSize  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [TagW-1:0] request_tag;
    logic [TokW-1:0] token_amount;
    logic [TokW-1:0] cached_amount;
    logic [SeqW-1:0] seq_amount;
  } in_item_t;

  typedef struct packed {
    logic              fits;
    logic [TokW-1:0]   remaining_tokens;
    logic [TokW-1:0]   prefill_slot;
    logic [Cnt32W-1:0] batched_total;
    logic [Cnt32W-1:0] cached_total;
    logic [Cnt16W-1:0] seq_total;
    logic [StatW-1:0]  status;
  } out_item_t;

  // table lookup request/response between core and table
  typedef struct packed {
    logic              start;
    logic              release_op;
    logic [IdWidth-1:0] id;
  } tbl_req_t;

  typedef struct packed {
    logic              done;
    logic [StatW-1:0]  status;
  } tbl_rsp_t;

endpackage

@@ rtl/core/btbt_if.sv @@
// Interfaces: valid/ready item channels and configuration write channel.
interface btbt_in_if;
  import btbt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface btbt_out_if;
  import btbt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface btbt_cfg_if;
  import btbt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/btbt_id_table.sv @@
// Request id table: tag memory with valid bits, swept for match and free entry.
module btbt_id_table
  import btbt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output tbl_rsp_t rsp_o
);

  typedef enum logic [1:0] {StIdle, StScan, StLast} state_e;

  logic [IdWidth-1:0] mem [IdTableDepth];
  logic [IdTableDepth-1:0] valid_q;
  state_e state_q;
  logic [CntW-1:0] addr_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdWidth-1:0] rd_data_q;
  logic rd_en_q;
  logic release_q;
  logic [IdWidth-1:0] id_q;
  logic hit_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  tbl_rsp_t rsp_q;

  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  logic match;

  assign match = rd_en_q && valid_q[rd_idx_q] && (rd_data_q == id_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= id_q;
    end
    rd_data_q <= mem[addr_q[IdxW-1:0]];
  end

  // new id goes to the lowest free entry, the last entry when only that one is free
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_found_q ? free_idx_q : rd_idx_q;
    if (state_q == StLast && !release_q && !hit_q && !match &&
        (free_found_q || !valid_q[rd_idx_q])) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      addr_q       <= '0;
      rd_idx_q     <= '0;
      rd_en_q      <= 1'b0;
      release_q    <= 1'b0;
      id_q         <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      rsp_q        <= '0;
    end else begin
      rsp_q.done <= (state_q == StLast);
      unique case (state_q)
        StIdle: begin
          rd_en_q <= 1'b0;
          if (req_i.start) begin
            id_q         <= req_i.id;
            release_q    <= req_i.release_op;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            addr_q       <= '0;
            state_q      <= StScan;
          end
        end
        StScan: begin
          rd_en_q  <= 1'b1;
          rd_idx_q <= addr_q[IdxW-1:0];
          if (match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
          end
          if (rd_en_q && !valid_q[rd_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx_q;
          end
          if (addr_q == CntW'(IdTableDepth - 1)) begin
            state_q <= StLast;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        StLast: begin
          rd_en_q    <= 1'b0;
          state_q    <= StIdle;
          if (release_q) begin
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
              rsp_q.status <= StatOk;
            end else if (match) begin
              valid_q[rd_idx_q] <= 1'b0;
              rsp_q.status <= StatOk;
            end else begin
              rsp_q.status <= StatIgnore;
            end
          end else if (hit_q || match) begin
            rsp_q.status <= StatIgnore;
          end else if (free_found_q) begin
            valid_q[free_idx_q] <= 1'b1;
            rsp_q.status <= StatOk;
          end else if (!valid_q[rd_idx_q]) begin
            valid_q[rd_idx_q] <= 1'b1;
            rsp_q.status <= StatOk;
          end else begin
            rsp_q.status <= StatFull;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLast |=> rsp_q.done)
    else $error("table response missing");
  a_done_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.done |-> state_q == StIdle)
    else $error("table response outside idle");
  a_no_full_with_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_q.done && rsp_q.status == StatFull) |-> valid_q == '1)
    else $error("full reported with free entry");
`endif

endmodule

@@ rtl/core/batch_token_budget_tracker_unit.sv @@
// Top level: batch token budget tracker with two request id tables.
// Results: a table item's result is registered after the id table sweep, one entry per
// cycle, and the table's answer; a query item's result is valid the cycle after accept.
// Flow: one item at a time; the next is accepted the cycle after the result is
// taken, so no new item is taken while a table sweep or an unread result is pending.
// Reset: asynchronous, active low; counters, valid bits and registers reset; tags kept.
module batch_token_budget_tracker_unit
  import btbt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  btbt_cfg_if.sink   cfg,
  btbt_in_if.sink    in_ch,
  btbt_out_if.source out_ch
);

  typedef enum logic [1:0] {StIdle, StWait, StOut} state_e;

  state_e state_q;
  logic [TokW-1:0] token_limit_q, chunk_size_q;
  logic [SeqW-1:0] seq_limit_q;
  logic chunked_q;
  logic [Cnt32W-1:0] batched_q, cached_q;
  logic [Cnt16W-1:0] seqcnt_q;
  in_item_t item_q;
  out_item_t out_q;
  logic fits_q;
  tbl_req_t tok_req, seq_req;
  tbl_rsp_t tok_rsp, seq_rsp, rsp;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state_q == StIdle);
  assign out_ch.valid = (state_q == StOut);
  assign out_ch.payload = out_q;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  logic is_tbl_op;
  assign is_tbl_op = (in_ch.payload.opcode == OpChargeTok) ||
                     (in_ch.payload.opcode == OpChargeSeq) ||
                     (in_ch.payload.opcode == OpReleaseTok) ||
                     (in_ch.payload.opcode == OpReleaseSeq);

  always_comb begin
    tok_req.id = IdWidth'(in_ch.payload.request_tag);
    tok_req.release_op = (in_ch.payload.opcode == OpReleaseTok);
    tok_req.start = accept && ((in_ch.payload.opcode == OpChargeTok) ||
                               (in_ch.payload.opcode == OpReleaseTok));
    seq_req.id = IdWidth'(in_ch.payload.request_tag);
    seq_req.release_op = (in_ch.payload.opcode == OpReleaseSeq);
    seq_req.start = accept && ((in_ch.payload.opcode == OpChargeSeq) ||
                               (in_ch.payload.opcode == OpReleaseSeq));
  end

  btbt_id_table u_tok_tbl (.clk_i, .rst_ni, .req_i(tok_req), .rsp_o(tok_rsp));
  btbt_id_table u_seq_tbl (.clk_i, .rst_ni, .req_i(seq_req), .rsp_o(seq_rsp));

  assign rsp = tok_rsp.done ? tok_rsp : seq_rsp;

  // counter update
  logic [Cnt32W:0] b_add, c_add;
  logic [Cnt16W:0] s_add;
  logic [Cnt32W-1:0] b_new, c_new;
  logic [Cnt16W-1:0] s_new;
  logic applied;
  logic [StatW-1:0] stat;

  always_comb begin
    applied = (state_q == StWait) && rsp.done && (rsp.status == StatOk);
    stat = (state_q == StWait && rsp.done) ? rsp.status : StatOk;
    b_add = {1'b0, batched_q} + (Cnt32W + 1)'(item_q.token_amount);
    c_add = {1'b0, cached_q} + (Cnt32W + 1)'(item_q.cached_amount);
    s_add = {1'b0, seqcnt_q} + (Cnt16W + 1)'(item_q.seq_amount);
    b_new = batched_q;
    c_new = cached_q;
    s_new = seqcnt_q;
    if (applied) begin
      unique case (item_q.opcode)
        OpChargeTok: begin
          b_new = b_add[Cnt32W] ? '1 : b_add[Cnt32W-1:0];
          c_new = c_add[Cnt32W] ? '1 : c_add[Cnt32W-1:0];
        end
        OpChargeSeq: s_new = s_add[Cnt16W] ? '1 : s_add[Cnt16W-1:0];
        OpReleaseTok: b_new = (Cnt32W'(item_q.token_amount) > batched_q) ? '0 :
                              batched_q - Cnt32W'(item_q.token_amount);
        OpReleaseSeq: s_new = (Cnt16W'(item_q.seq_amount) > seqcnt_q) ? '0 :
                              seqcnt_q - Cnt16W'(item_q.seq_amount);
        default: ;
      endcase
    end
  end

  logic [Cnt32W-1:0] rem_full;
  logic [TokW-1:0] remaining, slot;
  always_comb begin
    rem_full = (b_new > Cnt32W'(token_limit_q)) ? '0 : Cnt32W'(token_limit_q) - b_new;
    remaining = rem_full[TokW-1:0];
    if (!chunked_q) slot = remaining;
    else slot = (chunk_size_q != '0) ? chunk_size_q : token_limit_q;
  end

  logic [Cnt32W:0] fit_b;
  logic [Cnt16W:0] fit_s;
  assign fit_b = {1'b0, batched_q} + (Cnt32W + 1)'(in_ch.payload.token_amount);
  assign fit_s = {1'b0, seqcnt_q} + (Cnt16W + 1)'(in_ch.payload.seq_amount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      token_limit_q <= TokW'(8192);
      seq_limit_q   <= SeqW'(256);
      chunked_q     <= 1'b0;
      chunk_size_q  <= '0;
      batched_q     <= '0;
      cached_q      <= '0;
      seqcnt_q      <= '0;
      item_q        <= '0;
      out_q         <= '0;
      fits_q        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          RegTokenLimit: token_limit_q <= cfg.data[TokW-1:0];
          RegSeqLimit:   seq_limit_q   <= cfg.data[SeqW-1:0];
          RegChunkedEn:  chunked_q     <= cfg.data[0];
          RegChunkSize:  chunk_size_q  <= cfg.data[TokW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            item_q  <= in_ch.payload;
            fits_q  <= (fit_b <= (Cnt32W + 1)'(token_limit_q)) &&
                       (fit_s <= (Cnt16W + 1)'(seq_limit_q));
            state_q <= is_tbl_op ? StWait : StOut;
            if (!is_tbl_op) begin
              out_q.fits <= (fit_b <= (Cnt32W + 1)'(token_limit_q)) &&
                            (fit_s <= (Cnt16W + 1)'(seq_limit_q));
              out_q.remaining_tokens <= remaining;
              out_q.prefill_slot <= slot;
              out_q.batched_total <= batched_q;
              out_q.cached_total <= cached_q;
              out_q.seq_total <= seqcnt_q;
              out_q.status <= StatOk;
            end
          end
        end
        StWait: begin
          if (rsp.done) begin
            batched_q <= b_new;
            cached_q  <= c_new;
            seqcnt_q  <= s_new;
            out_q.fits <= fits_q;
            out_q.remaining_tokens <= remaining;
            out_q.prefill_slot <= slot;
            out_q.batched_total <= b_new;
            out_q.cached_total <= c_new;
            out_q.seq_total <= s_new;
            out_q.status <= stat;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_ch.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tok_rsp.done && seq_rsp.done))
    else $error("both tables answered");
  a_rsp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_rsp.done || seq_rsp.done) |-> state_q == StWait)
    else $error("table answer outside wait");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_q.status != 2'd3)
    else $error("bad status");
`endif

endmodule
